FILE: rtl/core/i2cbw_pkg.sv
// Shared types and constants for the I2C byte-write master.
`default_nettype none
package i2cbw_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIT_CNT_W = 4;
  localparam int unsigned BYTE_NR_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_ADDRESS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_DATA     = 8'd2;

  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RST = 8'hA0;
  localparam logic [BYTE_W-1:0] WORD_ADDRESS_RST   = 8'hAA;
  localparam logic [BYTE_W-1:0] WRITE_DATA_RST     = 8'h55;

  localparam logic [BYTE_NR_W-1:0] BYTE_DEVICE = 2'd0;
  localparam logic [BYTE_NR_W-1:0] BYTE_WORD   = 2'd1;
  localparam logic [BYTE_NR_W-1:0] BYTE_DATA   = 2'd2;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_S0    = 4'd1,
    PH_S1    = 4'd2,
    PH_S2    = 4'd3,
    PH_S3    = 4'd4,
    PH_SETUP = 4'd5,
    PH_HIGH  = 4'd6,
    PH_LOW   = 4'd7,
    PH_GAP   = 4'd8,
    PH_AHIGH = 4'd9,
    PH_ALOW  = 4'd10,
    PH_P0    = 4'd11,
    PH_P1    = 4'd12,
    PH_P2    = 4'd13,
    PH_P3    = 4'd14
  } phase_t;

endpackage
`default_nettype wire

FILE: rtl/core/i2c_eeprom_byte_write_master_unit.sv
// I2C master bit sequencer for a single-byte EEPROM write.
//
// Each input beat is one bit-timing tick carrying go and the sampled SDA
// level; each accepted beat gives exactly one result beat with the SCL/SDA
// levels, SDA drive enable, busy, acknowledge status, byte number and done.
// A go on an idle tick runs one transaction: start, device address, word
// address and data byte (MSB first, three ticks a bit, then a gap tick and
// two acknowledge ticks), then stop: 89 ticks, done on the last one.
// Each result beat is registered, valid in the cycle after its input beat;
// one beat per cycle is sustained while out_ready holds, the sequencer
// state and output register both being updated in the accepting cycle.
// in_ready is high while the output register is empty or being drained, so
// a stalled receiver holds the result and blocks further input beats only
// until it takes it. Configuration writes (cfg_index 0..2, other indices
// ignored) are always accepted; a byte is latched when its first bit begins.
// Synchronous reset returns the sequencer to idle with both line latches
// low, the registers to A0/AA/55 and the output register to empty.
`default_nettype none
module i2c_eeprom_byte_write_master_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_go,
  input  wire logic                            in_sda_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_scl_level,
  output logic                                 out_sda_level,
  output logic                                 out_sda_drive,
  output logic                                 out_busy_res,
  output logic                                 out_ack_valid,
  output logic                                 out_ack_seen,
  output logic [i2cbw_pkg::BYTE_NR_W-1:0]      out_byte_number,
  output logic                                 out_done_res,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [i2cbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [i2cbw_pkg::BYTE_W-1:0]    cfg_data
);
  import i2cbw_pkg::*;

  logic [BYTE_W-1:0]    dev_addr_r, word_addr_r, wr_data_r;
  phase_t               phase_r, phase_nxt, cur_phase;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [BYTE_NR_W-1:0] byte_cnt_r, byte_cnt_nxt, byte_cur, byte_out;
  logic [BYTE_W-1:0]    shift_r, shift_nxt, load_val;
  logic                 scl_r, scl_nxt, sda_r, sda_nxt;
  logic                 drive, busy, ackv, acks, done;
  logic                 in_acc;

  logic                 out_valid_r;
  logic                 out_scl_r, out_sda_r, out_drive_r, out_busy_r;
  logic                 out_ackv_r, out_acks_r, out_done_r;
  logic [BYTE_NR_W-1:0] out_byte_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEVICE_ADDRESS_RST;
      word_addr_r <= WORD_ADDRESS_RST;
      wr_data_r   <= WRITE_DATA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r  <= cfg_data;
        CFG_WORD_ADDRESS:   word_addr_r <= cfg_data;
        CFG_WRITE_DATA:     wr_data_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Idle and the unused code both fall through to a possible start.
  always_comb begin
    cur_phase = phase_r;
    byte_cur  = byte_cnt_r;
    case (phase_r)
      PH_S0, PH_S1, PH_S2, PH_S3, PH_SETUP, PH_HIGH, PH_LOW, PH_GAP,
      PH_AHIGH, PH_ALOW, PH_P0, PH_P1, PH_P2, PH_P3: cur_phase = phase_r;
      default: begin
        if (in_go) begin
          cur_phase = PH_S0;
          byte_cur  = BYTE_DEVICE;
        end else begin
          cur_phase = PH_IDLE;
        end
      end
    endcase
  end

  assign bit_inc = bit_cnt_r + 1'b1;

  // Next state
  always_comb begin
    phase_nxt   = cur_phase;
    bit_cnt_nxt = bit_cnt_r;
    byte_out    = byte_cur;
    shift_nxt   = shift_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    load_val    = wr_data_r;
    case (cur_phase)
      PH_S0: begin sda_nxt = 1'b1; phase_nxt = PH_S1; end
      PH_S1: begin scl_nxt = 1'b1; phase_nxt = PH_S2; end
      PH_S2: begin sda_nxt = 1'b0; phase_nxt = PH_S3; end
      PH_S3: begin
        scl_nxt     = 1'b0;
        shift_nxt   = dev_addr_r;
        bit_cnt_nxt = '0;
        phase_nxt   = PH_SETUP;
      end
      PH_SETUP: begin sda_nxt = shift_r[BYTE_W-1]; phase_nxt = PH_HIGH; end
      PH_HIGH:  begin scl_nxt = 1'b1; phase_nxt = PH_LOW; end
      PH_LOW: begin
        scl_nxt     = 1'b0;
        shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_inc;
        phase_nxt   = (bit_inc >= BITS_PER_BYTE) ? PH_GAP : PH_SETUP;
      end
      PH_GAP:   begin sda_nxt = 1'b0; phase_nxt = PH_AHIGH; end
      PH_AHIGH: begin scl_nxt = 1'b1; phase_nxt = PH_ALOW; end
      PH_ALOW: begin
        scl_nxt = 1'b0;
        if (byte_cur >= BYTE_DATA) begin
          phase_nxt = PH_P0;
        end else begin
          byte_out    = byte_cur + 1'b1;
          load_val    = (byte_out == BYTE_WORD) ? word_addr_r : wr_data_r;
          shift_nxt   = load_val;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_SETUP;
        end
      end
      PH_P0: begin sda_nxt = 1'b0; phase_nxt = PH_P1; end
      PH_P1: begin scl_nxt = 1'b1; phase_nxt = PH_P2; end
      PH_P2: begin sda_nxt = 1'b1; phase_nxt = PH_P3; end
      PH_P3: begin scl_nxt = 1'b0; phase_nxt = PH_IDLE; end
      default: phase_nxt = PH_IDLE;
    endcase
    byte_cnt_nxt = (cur_phase == PH_P3) ? BYTE_DEVICE : byte_out;
  end

  // Beat flags
  always_comb begin
    drive = 1'b1;
    busy  = 1'b1;
    ackv  = 1'b0;
    acks  = 1'b0;
    done  = 1'b0;
    case (cur_phase)
      PH_IDLE:  busy = 1'b0;
      PH_AHIGH: begin drive = 1'b0; ackv = 1'b1; acks = !in_sda_in; end
      PH_ALOW:  drive = 1'b0;
      PH_P3:    done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      byte_cnt_r <= '0;
      shift_r    <= '0;
      scl_r      <= 1'b0;
      sda_r      <= 1'b0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      shift_r    <= shift_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_scl_r   <= scl_nxt;
      out_sda_r   <= sda_nxt;
      out_drive_r <= drive;
      out_busy_r  <= busy;
      out_ackv_r  <= ackv;
      out_acks_r  <= acks;
      out_byte_r  <= byte_out;
      out_done_r  <= done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_level   = out_scl_r;
  assign out_sda_level   = out_sda_r;
  assign out_sda_drive   = out_drive_r;
  assign out_busy_res    = out_busy_r;
  assign out_ack_valid   = out_ackv_r;
  assign out_ack_seen    = out_acks_r;
  assign out_byte_number = out_byte_r;
  assign out_done_res    = out_done_r;

  // the stop ends with SCL pulled low again
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_busy_res && !out_scl_level && out_sda_drive))
    else $error("done beat without busy, with SCL high or SDA released");

  a_ack_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ack_valid) |-> (!out_sda_drive && out_scl_level))
    else $error("acknowledge sample while SDA driven or SCL low");

  a_seen_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ack_seen) |-> out_ack_valid)
    else $error("ack_seen outside an acknowledge beat");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |=> (phase_r == PH_IDLE && byte_cnt_r == BYTE_DEVICE))
    else $error("sequencer not idle after stop");

endmodule
`default_nettype wire
